### hdl/rational_arithmetic_unit_assert.svh
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_assert
// Assertion macros shared by the rational arithmetic unit.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication
`define RAU_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RAU_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Types and constants for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int OPERAND_WIDTH = 32;  // live bits of each operand field (8..32)
    localparam int MAG_W         = 32;  // operand magnitude width
    localparam int WIDE_W        = 64;  // serial unit width

    localparam int MUL_STEPS = MAG_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);
    localparam int DIV_STEPS = WIDE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int SHIFT_W   = $clog2(WIDE_W);

    localparam logic [2:0] KIND_ADD = 3'd0;
    localparam logic [2:0] KIND_SUB = 3'd1;
    localparam logic [2:0] KIND_MUL = 3'd2;
    localparam logic [2:0] KIND_DIV = 3'd3;
    localparam logic [2:0] KIND_EQ  = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } rau_req_t;

    typedef struct packed {
        logic signed [63:0] res_num;
        logic signed [63:0] res_den;
        logic               equal_flag;
        logic [1:0]         status;
    } rau_rsp_t;

    // command into a serial unit
    typedef struct packed {
        logic              start;
        logic [WIDE_W-1:0] x;
        logic [WIDE_W-1:0] y;
    } rau_op_t;

    // answer from a serial unit
    typedef struct packed {
        logic              done;
        logic [WIDE_W-1:0] value;
    } rau_res_t;

endpackage

### hdl/rau_mul.sv
// ----------------------------------------------------------------------------
// rau_mul
// Shift-and-add magnitude multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rau_mul (
    input  logic            clk,
    input  logic            rst_n,
    input  rau_pkg::rau_op_t  op,
    output rau_pkg::rau_res_t res
);
    import rau_pkg::*;

    logic                 busy_reg,   busy_next;
    logic                 done_reg,   done_next;
    logic [MUL_CNT_W-1:0] cnt_reg,    cnt_next;
    logic [WIDE_W-1:0]    acc_reg,    acc_next;
    logic [WIDE_W-1:0]    mcand_reg,  mcand_next;
    logic [MAG_W-1:0]     mplier_reg, mplier_next;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (op.start)
        begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            acc_next    = '0;
            mcand_next  = op.x;
            mplier_next = op.y[MAG_W-1:0];
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
            acc_reg    <= '0;
            mcand_reg  <= '0;
            mplier_reg <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
            acc_reg    <= acc_next;
            mcand_reg  <= mcand_next;
            mplier_reg <= mplier_next;
        end
    end

    assign res.done  = done_reg;
    assign res.value = acc_reg;

endmodule

### hdl/rau_div.sv
// ----------------------------------------------------------------------------
// rau_div
// Restoring divider, one quotient bit per cycle; x / y with y nonzero.
// ----------------------------------------------------------------------------
module rau_div (
    input  logic            clk,
    input  logic            rst_n,
    input  rau_pkg::rau_op_t  op,
    output rau_pkg::rau_res_t res
);
    import rau_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg,  cnt_next;
    logic [WIDE_W-1:0]    quo_reg,  quo_next;
    logic [WIDE_W-1:0]    rem_reg,  rem_next;
    logic [WIDE_W-1:0]    dvs_reg,  dvs_next;
    logic [WIDE_W:0]      trial;
    logic [WIDE_W:0]      diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[WIDE_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        if (op.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = op.x;
            rem_next  = '0;
            dvs_next  = op.y;
        end
        else if (busy_reg)
        begin
            if (!diff[WIDE_W])
            begin
                rem_next = diff[WIDE_W-1:0];
                quo_next = {quo_reg[WIDE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[WIDE_W-1:0];
                quo_next = {quo_reg[WIDE_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
        end
    end

    assign res.done  = done_reg;
    assign res.value = quo_reg;

endmodule

### hdl/rau_gcd.sv
// ----------------------------------------------------------------------------
// rau_gcd
// Binary gcd, one halving or subtraction per cycle; gcd(0,0) is 0.
// ----------------------------------------------------------------------------
module rau_gcd (
    input  logic            clk,
    input  logic            rst_n,
    input  rau_pkg::rau_op_t  op,
    output rau_pkg::rau_res_t res
);
    import rau_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [WIDE_W-1:0]  a_reg,    a_next;
    logic [WIDE_W-1:0]  b_reg,    b_next;
    logic [SHIFT_W-1:0] k_reg,    k_next;
    logic [WIDE_W-1:0]  g_reg,    g_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        k_next    = k_reg;
        g_next    = g_reg;
        if (op.start)
        begin
            busy_next = 1'b1;
            a_next    = op.x;
            b_next    = op.y;
            k_next    = '0;
        end
        else if (busy_reg)
        begin
            if (a_reg == '0)
            begin
                g_next    = b_reg << k_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (b_reg == '0)
            begin
                g_next    = a_reg << k_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (!a_reg[0] && !b_reg[0])
            begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            else if (!a_reg[0])
            begin
                a_next = a_reg >> 1;
            end
            else if (!b_reg[0])
            begin
                b_next = b_reg >> 1;
            end
            else if (a_reg >= b_reg)
            begin
                a_next = a_reg - b_reg;
            end
            else
            begin
                b_next = b_reg - a_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            a_reg    <= '0;
            b_reg    <= '0;
            k_reg    <= '0;
            g_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            a_reg    <= a_next;
            b_reg    <= b_next;
            k_reg    <= k_next;
            g_reg    <= g_next;
        end
    end

    assign res.done  = done_reg;
    assign res.value = g_reg;

endmodule

### hdl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Add, subtract, multiply, divide or compare two gcd-reduced rationals.
// ----------------------------------------------------------------------------
// One word at a time: req_stall is high from acceptance until the result
// has been moved to the output register, which then waits for rsp_stall to
// drop while the next request is taken. Latency is set by three serial
// units run one after another. The binary gcd does one halving or
// subtraction per cycle, over up to three passes: one on each operand and
// one on the result. The restoring divider does six divisions, two per gcd
// pass; an operand with gcd 0 skips its two, and an equality test or a zero
// over zero result skips the last two along with the result pass. The
// shift-add multiplier forms two or three products. Unused kind codes go
// straight to the output. Signs are carried as sign and magnitude and are
// never normalised, so 1/-2 stays 1/-2.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  rau_pkg::rau_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output rau_pkg::rau_rsp_t rsp
);
    import rau_pkg::*;

`include "rational_arithmetic_unit_assert.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_GA, S_DAN, S_DAD, S_GB, S_DBN, S_DBD,
        S_M1, S_M2, S_M3, S_COMB, S_GR, S_DRN, S_DRD, S_CHK, S_FIN
    } state_t;

    // sign-extend the live operand bits to the full field width
    function automatic logic [31:0] sext_op(input logic [31:0] raw);
        logic [31:0] v;
        for (int i = 0; i < 32; i++)
        begin
            v[i] = (i < OPERAND_WIDTH) ? raw[i] : raw[OPERAND_WIDTH-1];
        end
        return v;
    endfunction

    function automatic logic [MAG_W-1:0] mag_op(input logic [31:0] v);
        return v[31] ? (MAG_W'(0) - v) : v;
    endfunction

    state_t            state_reg, state_next;
    logic              launch_reg, launch_next;
    logic [2:0]        kind_reg, kind_next;
    logic              an_s_reg, ad_s_reg, bn_s_reg, bd_s_reg;
    logic              an_s_next, ad_s_next, bn_s_next, bd_s_next;
    logic [MAG_W-1:0]  an_reg, ad_reg, bn_reg, bd_reg;
    logic [MAG_W-1:0]  an_next, ad_next, bn_next, bd_next;
    logic [WIDE_W-1:0] g_reg, g_next;
    logic [WIDE_W-1:0] p_reg, q_reg, d_reg, p_next, q_next, d_next;
    logic              p_s_reg, q_s_reg, d_s_reg, p_s_next, q_s_next, d_s_next;
    logic [WIDE_W-1:0] nm_reg, dm_reg, nm_next, dm_next;
    logic              ns_reg, ds_reg, ns_next, ds_next;
    rau_rsp_t          hold_reg, hold_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rau_rsp_t          rsp_reg, rsp_next;

    rau_op_t  gcd_op, div_op, mul_op;
    rau_res_t gcd_res, div_res, mul_res;

    rau_gcd u_gcd (.clk(clk), .rst_n(rst_n), .op(gcd_op), .res(gcd_res));
    rau_div u_div (.clk(clk), .rst_n(rst_n), .op(div_op), .res(div_res));
    rau_mul u_mul (.clk(clk), .rst_n(rst_n), .op(mul_op), .res(mul_res));

    logic [31:0]       e_an, e_ad, e_bn, e_bd;
    logic              qs_eff, sum_s;
    logic [WIDE_W-1:0] sum_m;
    logic              n_fit, d_fit;
    logic              prod_s;
    logic              is_sum;

    always_comb
    begin
        state_next     = state_reg;
        launch_next    = launch_reg;
        kind_next      = kind_reg;
        an_s_next = an_s_reg; ad_s_next = ad_s_reg;
        bn_s_next = bn_s_reg; bd_s_next = bd_s_reg;
        an_next = an_reg; ad_next = ad_reg; bn_next = bn_reg; bd_next = bd_reg;
        g_next  = g_reg;
        p_next  = p_reg; q_next = q_reg; d_next = d_reg;
        p_s_next = p_s_reg; q_s_next = q_s_reg; d_s_next = d_s_reg;
        nm_next = nm_reg; dm_next = dm_reg; ns_next = ns_reg; ds_next = ds_reg;
        hold_next      = hold_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        gcd_op = '0;
        div_op = '0;
        mul_op = '0;

        e_an = sext_op(req.a_num);
        e_ad = sext_op(req.a_den);
        e_bn = sext_op(req.b_num);
        e_bd = sext_op(req.b_den);

        is_sum = (kind_reg == KIND_ADD) || (kind_reg == KIND_SUB);

        // signed sum of the two cross products
        qs_eff = (kind_reg == KIND_SUB) ? !q_s_reg : q_s_reg;
        if (p_s_reg == qs_eff)
        begin
            sum_m = p_reg + q_reg;
            sum_s = p_s_reg;
        end
        else if (p_reg >= q_reg)
        begin
            sum_m = p_reg - q_reg;
            sum_s = p_s_reg;
        end
        else
        begin
            sum_m = q_reg - p_reg;
            sum_s = qs_eff;
        end
        if (sum_m == '0)
        begin
            sum_s = 1'b0;
        end

        n_fit = !nm_reg[WIDE_W-1] || (ns_reg && (nm_reg[WIDE_W-2:0] == '0));
        d_fit = !dm_reg[WIDE_W-1] || (ds_reg && (dm_reg[WIDE_W-2:0] == '0));

        // sign of the product that has just finished
        prod_s = 1'b0;
        gcd_op.x = '0;
        gcd_op.y = '0;

        // word leaves the output register
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next = req.kind;
                    an_s_next = e_an[31]; an_next = mag_op(e_an);
                    ad_s_next = e_ad[31]; ad_next = mag_op(e_ad);
                    bn_s_next = e_bn[31]; bn_next = mag_op(e_bn);
                    bd_s_next = e_bd[31]; bd_next = mag_op(e_bd);
                    hold_next = '0;
                    launch_next = 1'b0;
                    if (req.kind inside {KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV, KIND_EQ})
                    begin
                        state_next = S_GA;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_GA, S_GB, S_GR:
            begin
                if (state_reg == S_GA)
                begin
                    gcd_op.x = WIDE_W'(an_reg);
                    gcd_op.y = WIDE_W'(ad_reg);
                end
                else if (state_reg == S_GB)
                begin
                    gcd_op.x = WIDE_W'(bn_reg);
                    gcd_op.y = WIDE_W'(bd_reg);
                end
                else
                begin
                    gcd_op.x = nm_reg;
                    gcd_op.y = dm_reg;
                end
                gcd_op.start = !launch_reg;
                launch_next  = 1'b1;
                if (gcd_res.done && launch_reg)
                begin
                    launch_next = 1'b0;
                    g_next      = gcd_res.value;
                    case (state_reg)
                        S_GA:    state_next = (gcd_res.value == '0) ? S_GB : S_DAN;
                        S_GB:    state_next = (gcd_res.value == '0) ? S_M1 : S_DBN;
                        default: state_next = S_DRN;
                    endcase
                end
            end
            S_DAN, S_DAD, S_DBN, S_DBD, S_DRN, S_DRD:
            begin
                case (state_reg)
                    S_DAN:   div_op.x = WIDE_W'(an_reg);
                    S_DAD:   div_op.x = WIDE_W'(ad_reg);
                    S_DBN:   div_op.x = WIDE_W'(bn_reg);
                    S_DBD:   div_op.x = WIDE_W'(bd_reg);
                    S_DRN:   div_op.x = nm_reg;
                    default: div_op.x = dm_reg;
                endcase
                div_op.y     = g_reg;
                div_op.start = !launch_reg;
                launch_next  = 1'b1;
                if (div_res.done && launch_reg)
                begin
                    launch_next = 1'b0;
                    case (state_reg)
                        S_DAN:
                        begin
                            an_next    = div_res.value[MAG_W-1:0];
                            state_next = S_DAD;
                        end
                        S_DAD:
                        begin
                            ad_next    = div_res.value[MAG_W-1:0];
                            state_next = S_GB;
                        end
                        S_DBN:
                        begin
                            bn_next    = div_res.value[MAG_W-1:0];
                            state_next = S_DBD;
                        end
                        S_DBD:
                        begin
                            bd_next    = div_res.value[MAG_W-1:0];
                            state_next = S_M1;
                        end
                        S_DRN:
                        begin
                            nm_next    = div_res.value;
                            state_next = S_DRD;
                        end
                        default:
                        begin
                            dm_next    = div_res.value;
                            state_next = S_CHK;
                        end
                    endcase
                end
            end
            S_M1, S_M2, S_M3:
            begin
                // M1: an*bn for a product, else an*bd
                // M2: ad*bd for a product, ad*bn otherwise; M3: ad*bd
                case (state_reg)
                    S_M1:
                    begin
                        mul_op.x = WIDE_W'(an_reg);
                        mul_op.y = (kind_reg == KIND_MUL) ? WIDE_W'(bn_reg) : WIDE_W'(bd_reg);
                        prod_s   = an_s_reg ^ ((kind_reg == KIND_MUL) ? bn_s_reg : bd_s_reg);
                    end
                    S_M2:
                    begin
                        mul_op.x = WIDE_W'(ad_reg);
                        mul_op.y = (kind_reg == KIND_MUL) ? WIDE_W'(bd_reg) : WIDE_W'(bn_reg);
                        prod_s   = ad_s_reg ^ ((kind_reg == KIND_MUL) ? bd_s_reg : bn_s_reg);
                    end
                    default:
                    begin
                        mul_op.x = WIDE_W'(ad_reg);
                        mul_op.y = WIDE_W'(bd_reg);
                        prod_s   = ad_s_reg ^ bd_s_reg;
                    end
                endcase
                mul_op.start = !launch_reg;
                launch_next  = 1'b1;
                if (mul_res.done && launch_reg)
                begin
                    launch_next = 1'b0;
                    prod_s      = prod_s && (mul_res.value != '0);
                    case (state_reg)
                        S_M1:
                        begin
                            p_next = mul_res.value; p_s_next = prod_s;
                            state_next = S_M2;
                        end
                        S_M2:
                        begin
                            q_next = mul_res.value; q_s_next = prod_s;
                            state_next = is_sum ? S_M3 : S_COMB;
                        end
                        default:
                        begin
                            d_next = mul_res.value; d_s_next = prod_s;
                            state_next = S_COMB;
                        end
                    endcase
                end
            end
            S_COMB:
            begin
                if (is_sum)
                begin
                    nm_next = sum_m;  ns_next = sum_s;
                    dm_next = d_reg;  ds_next = d_s_reg;
                end
                else
                begin
                    nm_next = p_reg;  ns_next = p_s_reg;
                    dm_next = q_reg;  ds_next = q_s_reg;
                end
                if (kind_reg == KIND_EQ)
                begin
                    // zero cross products carry no sign, so zero equals zero
                    hold_next.equal_flag = (p_reg == q_reg) && (p_s_reg == q_s_reg);
                    state_next = S_FIN;
                end
                else if ((is_sum ? sum_m : p_reg) == '0 && (is_sum ? d_reg : q_reg) == '0)
                begin
                    hold_next.status = ST_ZERO;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_GR;
                end
            end
            S_CHK:
            begin
                if (n_fit && d_fit)
                begin
                    hold_next.res_num = ns_reg ? (WIDE_W'(0) - nm_reg) : nm_reg;
                    hold_next.res_den = ds_reg ? (WIDE_W'(0) - dm_reg) : dm_reg;
                end
                else
                begin
                    hold_next.status = ST_OVF;
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = hold_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            launch_reg    <= 1'b0;
            kind_reg      <= '0;
            an_s_reg <= 1'b0; ad_s_reg <= 1'b0; bn_s_reg <= 1'b0; bd_s_reg <= 1'b0;
            an_reg   <= '0;   ad_reg   <= '0;   bn_reg   <= '0;   bd_reg   <= '0;
            g_reg    <= '0;
            p_reg    <= '0;   q_reg    <= '0;   d_reg    <= '0;
            p_s_reg  <= 1'b0; q_s_reg  <= 1'b0; d_s_reg  <= 1'b0;
            nm_reg   <= '0;   dm_reg   <= '0;   ns_reg   <= 1'b0; ds_reg <= 1'b0;
            hold_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            kind_reg      <= kind_next;
            an_s_reg <= an_s_next; ad_s_reg <= ad_s_next;
            bn_s_reg <= bn_s_next; bd_s_reg <= bd_s_next;
            an_reg   <= an_next;   ad_reg   <= ad_next;
            bn_reg   <= bn_next;   bd_reg   <= bd_next;
            g_reg    <= g_next;
            p_reg    <= p_next;    q_reg    <= q_next;    d_reg <= d_next;
            p_s_reg  <= p_s_next;  q_s_reg  <= q_s_next;  d_s_reg <= d_s_next;
            nm_reg   <= nm_next;   dm_reg   <= dm_next;
            ns_reg   <= ns_next;   ds_reg   <= ds_next;
            hold_reg      <= hold_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `RAU_ASSERT_NXT(a_busy_after_accept, clk, rst_n, req_valid && !req_stall, req_stall, "accepted word did not start work")
    `RAU_ASSERT_IMP(a_ovf_zero, clk, rst_n, rsp_valid && rsp.status == ST_OVF, rsp.res_num == 0 && rsp.res_den == 0, "overflow word carries a value")
    `RAU_ASSERT_IMP(a_eq_clean, clk, rst_n, rsp_valid && rsp.equal_flag, rsp.res_num == 0 && rsp.res_den == 0 && rsp.status == ST_OK, "equality word not clean")
    `RAU_ASSERT_IMP(a_gcd_nonzero, clk, rst_n, state_reg == S_DRN || state_reg == S_DRD, g_reg != 0, "result divided by zero gcd")

endmodule

### tb/rational_arithmetic_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_tb
// Self-checking bench for the rational arithmetic unit.
// ----------------------------------------------------------------------------
// A directed set of words (field extremes, every operation, zero over zero,
// zero denominators, unused kind codes) is followed by random words. Half
// of the random operand fields are small values, so the reduction and sign
// handling get worked hard; the rest are full-width values, powers of two
// and field extremes. The random run has four phases with different idling
// patterns on both sides. An internal predictor works out each expected
// result, and a scoreboard compares it field by field.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;
    import rau_pkg::*;

    localparam int  N_RANDOM    = 2000;
    localparam int  N_PHASES    = 4;
    localparam longint MAX_CYC  = 64'd40_000_000;
    localparam logic [63:0] TOP = 64'h8000_0000_0000_0000;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    rau_req_t req;
    logic     rsp_valid;
    logic     rsp_stall;
    rau_rsp_t rsp;

    int     send_idle_pct;   // chance, in percent, the sender idles a cycle
    int     recv_stall_pct;  // chance, in percent, the receiver stalls a cycle
    longint cycle_count;
    int     words_sent;

    // ------------------------------------------------------------------------
    // Scoreboard: works out the expected result of each accepted word and
    // checks results in order against it.
    // ------------------------------------------------------------------------
    class rational_scoreboard;
        rau_rsp_t pending_results[$];
        int       n_fail;
        int       n_checked;
        int       n_zero_zero;
        int       n_overflow;
        int       n_equal;

        function logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
            logic [63:0] t;
            while (y != 0)
            begin
                t = x % y;
                x = y;
                y = t;
            end
            return x;
        endfunction

        function logic [63:0] magnitude(logic signed [63:0] v);
            return v[63] ? 64'(-v) : 64'(v);
        endfunction

        // live bits of a field, sign-extended from OPERAND_WIDTH-1
        function logic signed [63:0] widen(logic [31:0] raw);
            logic signed [63:0] t;
            t = {32'b0, raw};
            t = t <<< (64 - OPERAND_WIDTH);
            return t >>> (64 - OPERAND_WIDTH);
        endfunction

        function void cancel(inout logic signed [63:0] n, inout logic signed [63:0] d);
            logic [63:0] g;
            g = gcd64(magnitude(n), magnitude(d));
            if (g != 0)
            begin
                n = n / $signed(g);
                d = d / $signed(g);
            end
        endfunction

        function rau_rsp_t expected_result(rau_req_t w);
            logic signed [63:0] an, ad, bn, bd;
            logic signed [65:0] nwide, dwide;
            logic               nneg, dneg;
            logic [63:0]        nmag, dmag, g;
            rau_rsp_t           r;
            r  = '0;
            an = widen(w.a_num);
            ad = widen(w.a_den);
            bn = widen(w.b_num);
            bd = widen(w.b_den);
            cancel(an, ad);
            cancel(bn, bd);
            case (w.kind)
                KIND_ADD, KIND_SUB:
                begin
                    nwide = (w.kind == KIND_ADD) ? 66'(an * bd) + 66'(bn * ad)
                                                 : 66'(an * bd) - 66'(bn * ad);
                    dwide = 66'(ad * bd);
                end
                KIND_MUL:
                begin
                    nwide = 66'(an * bn);
                    dwide = 66'(ad * bd);
                end
                KIND_DIV:
                begin
                    nwide = 66'(an * bd);
                    dwide = 66'(ad * bn);
                end
                KIND_EQ:
                begin
                    r.equal_flag = (an * bd == bn * ad);
                    return r;
                end
                default: return r;
            endcase
            nneg = nwide < 0;
            dneg = dwide < 0;
            nmag = nneg ? 64'(-nwide) : 64'(nwide);
            dmag = dneg ? 64'(-dwide) : 64'(dwide);
            if (nmag == 0 && dmag == 0)
            begin
                r.status = ST_ZERO;
                return r;
            end
            g    = gcd64(nmag, dmag);
            nmag = nmag / g;
            dmag = dmag / g;
            // negative side may reach 2^63, positive side must stay below it
            if ((nneg ? nmag > TOP : nmag >= TOP) || (dneg ? dmag > TOP : dmag >= TOP))
            begin
                r.status = ST_OVF;
                return r;
            end
            r.res_num = nneg ? -nmag : nmag;
            r.res_den = dneg ? -dmag : dmag;
            r.status  = ST_OK;
            return r;
        endfunction

        function void note_request(rau_req_t w);
            pending_results.push_back(expected_result(w));
        endfunction

        function void check_result(rau_rsp_t got);
            rau_rsp_t exp_r;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, got);
                n_fail++;
                return;
            end
            exp_r = pending_results.pop_front();
            n_checked++;
            if (exp_r.status == ST_ZERO) n_zero_zero++;
            if (exp_r.status == ST_OVF)  n_overflow++;
            if (exp_r.equal_flag)        n_equal++;
            if (got.res_num !== exp_r.res_num)
                $display("%0t: res_num expected %0d got %0d", $time, exp_r.res_num, got.res_num);
            if (got.res_den !== exp_r.res_den)
                $display("%0t: res_den expected %0d got %0d", $time, exp_r.res_den, got.res_den);
            if (got.equal_flag !== exp_r.equal_flag)
                $display("%0t: equal_flag expected %0b got %0b", $time,
                         exp_r.equal_flag, got.equal_flag);
            if (got.status !== exp_r.status)
                $display("%0t: status expected %0d got %0d", $time, exp_r.status, got.status);
            if (got !== exp_r) n_fail++;
        endfunction
    endclass

    rational_scoreboard sb;

    rational_arithmetic_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYC)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: stall decided at the falling edge, result taken at the rising
    always @(negedge clk)
        rsp_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(rsp);

    // Present one word, holding it until the block takes it. Called and
    // returns at a falling edge.
    task automatic send_word(rau_req_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req       <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        sb.note_request(w);
        words_sent++;
        @(negedge clk);
    endtask

    function automatic logic [31:0] random_operand();
        logic [31:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: v = 32'($signed($urandom_range(24)) - 12);
            5, 6:          v = $urandom;
            7:             v = 32'(1) << $urandom_range(31);
            8:             v = -(32'(1) << $urandom_range(31));
            default:
            begin
                case ($urandom_range(4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = 32'hffff_ffff;
                    3: v = 32'h0;
                    default: v = 32'h1;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic rau_req_t random_word();
        rau_req_t w;
        w.kind  = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                                            : 3'($urandom_range(4));
        w.a_num = random_operand();
        w.a_den = random_operand();
        w.b_num = random_operand();
        w.b_den = random_operand();
        return w;
    endfunction

    function automatic rau_req_t make_word(logic [2:0] k, logic [31:0] an, logic [31:0] ad,
                                           logic [31:0] bn, logic [31:0] bd);
        rau_req_t w;
        w.kind  = k;
        w.a_num = an;
        w.a_den = ad;
        w.b_num = bn;
        w.b_den = bd;
        return w;
    endfunction

    initial
    begin
        int phase;
        int i;
        int wait_cyc;
        sb             = new();
        cycle_count    = 0;
        words_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        req_valid      = 1'b0;
        req            = '0;
        rsp_stall      = 1'b0;
        rst_n          = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed words
        send_word(make_word(KIND_ADD, 1, 2, 1, 3));
        send_word(make_word(KIND_SUB, 1, 2, 1, 2));          // zero result
        send_word(make_word(KIND_MUL, -3, 4, 2, -9));
        send_word(make_word(KIND_DIV, 1, 2, 0, 5));          // divide by zero
        send_word(make_word(KIND_EQ, 2, 4, -1, -2));         // equal
        send_word(make_word(KIND_EQ, 1, 3, 1, 2));           // not equal
        send_word(make_word(KIND_EQ, 0, 0, 0, 0));           // zero cross products
        send_word(make_word(KIND_ADD, 0, 0, 0, 0));          // zero over zero
        send_word(make_word(KIND_MUL, 0, 0, 5, 7));          // operand zero over zero
        send_word(make_word(KIND_ADD, 5, 0, 3, 0));          // zero denominators
        send_word(make_word(KIND_SUB, 7, 0, -2, 1));
        send_word(make_word(KIND_ADD, 1, -2, 0, 1));         // sign kept as it comes
        send_word(make_word(KIND_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1));
        send_word(make_word(KIND_DIV, 32'h7fff_ffff, 32'h8000_0000,
                            32'h8000_0000, 32'h7fff_ffff));
        send_word(make_word(KIND_ADD, 32'h8000_0000, 32'h7fff_ffff,
                            32'h8000_0000, 32'h7fff_fffd));
        send_word(make_word(KIND_SUB, 32'h7fff_ffff, 32'h8000_0001,
                            32'h8000_0000, 32'h7fff_fffe));
        send_word(make_word(KIND_MUL, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1));
        send_word(make_word(3'd5, 1, 2, 3, 4));              // unused kind codes
        send_word(make_word(3'd6, 32'hffff_ffff, 0, 0, 0));
        send_word(make_word(3'd7, 32'h8000_0000, 32'h7fff_ffff, 1, 1));

        // random words, four idling phases
        for (phase = 0; phase < N_PHASES; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            for (i = 0; i < N_RANDOM / N_PHASES; i++)
                send_word(random_word());
        end
        req_valid <= 1'b0;

        wait_cyc = 0;
        while (sb.pending_results.size() != 0 && wait_cyc < 100000)
        begin
            @(posedge clk);
            wait_cyc++;
        end
        repeat (50) @(posedge clk);

        $display("Sent %0d words, checked %0d results (%0d zero-over-zero, %0d overflow,",
                 words_sent, sb.n_checked, sb.n_zero_zero, sb.n_overflow);
        $display("%0d equal) over four idling phases; %0d left pending, %0d failures.",
                 sb.n_equal, sb.pending_results.size(), sb.n_fail);
        if (sb.n_fail == 0 && sb.pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
